### rtl/lcdnw_pkg.sv
// Shared types, constants and helpers for the LCD nibble write sequencer.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package lcdnw_pkg;

  // Request kinds as carried on req_type_i
  typedef enum logic [1:0] {
    REQ_COMMAND = 2'd0,
    REQ_DATA    = 2'd1,
    REQ_POWERUP = 2'd2,
    REQ_TEXT    = 2'd3
  } req_type_e;

  // Configuration register indexes (word addresses on the APB port)
  typedef enum logic [1:0] {
    CFG_COMMAND_WAIT = 2'd0,
    CFG_DATA_WAIT    = 2'd1,
    CFG_WRAP_COLUMN  = 2'd2,
    CFG_MAX_TEXT_LEN = 2'd3
  } cfg_index_e;

  // Work kinds queued between front and back
  typedef enum logic [1:0] {
    JOB_BYTE      = 2'd0,  // one byte, two nibbles
    JOB_WRAP_BYTE = 2'd1,  // line-two command, then data byte
    JOB_POWERUP   = 2'd2   // fixed initialisation run
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic        rs;
    logic [7:0]  value;
  } job_t;

  typedef struct packed {
    logic [7:0] command_wait_us;
    logic [7:0] data_wait_us;
    logic [4:0] wrap_column;
    logic [7:0] max_text_length;
  } cfg_t;

  // Reset values of the configuration registers
  localparam logic [7:0] CommandWaitReset  = 8'd40;
  localparam logic [7:0] DataWaitReset     = 8'd50;
  localparam logic [4:0] WrapColumnReset   = 5'd16;
  localparam logic [7:0] MaxTextLenReset   = 8'd32;

  // Command and timing constants
  localparam logic [7:0]  LineTwoCmd      = 8'hC0;
  localparam logic [15:0] PowerupWaitUs   = 16'd50000;
  localparam logic [12:0] NibbleWaitUs    = 13'd40;
  localparam logic [12:0] FirstHoldUs     = 13'd5040;
  localparam logic [12:0] RepeatHoldUs    = 13'd190;
  localparam logic [12:0] ClearExtraUs    = 13'd2000;
  localparam logic [3:0]  PowerupNibA     = 4'h3;
  localparam logic [3:0]  PowerupNibB     = 4'h2;

  // Step counter covers the twelve-nibble power-up run
  localparam int unsigned StepW           = 4;
  localparam logic [StepW-1:0] LastByteStep    = 4'd1;
  localparam logic [StepW-1:0] LastWrapStep    = 4'd3;
  localparam logic [StepW-1:0] LastPowerupStep = 4'd11;
  localparam logic [StepW-1:0] FirstCmdStep    = 4'd4;

  // Index of the clear-display byte in the power-up command list
  localparam logic [1:0] ClearCmdIdx = 2'd2;

  localparam int unsigned QueueDepthDefault = 2;

  // Command bytes of the power-up run after the four raw nibbles
  function automatic logic [7:0] powerup_cmd(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h28;
      2'd1:    b = 8'h0C;
      2'd2:    b = 8'h01;
      default: b = 8'h06;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/lcdnw_fifo.sv
// Small job queue between the classifying front and the nibble back end.
// Depends on lcdnw_pkg for the job_t entry type.
`default_nettype none

module lcdnw_fifo import lcdnw_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault  // at least 2
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  wire  pop_i,
  output job_t head_o,
  output logic empty_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push_ok, pop_ok;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Fill count never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("queue fill count beyond depth");

  // Write and read pointers agree when the queue is empty
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

### rtl/lcdnw_front.sv
// Front end: accepts requests, tracks the text position and queues jobs.
// Depends on lcdnw_pkg; feeds lcdnw_fifo.
`default_nettype none

module lcdnw_front import lcdnw_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cfg_t       cfg_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [1:0] req_type_i,
  input  wire  [7:0] value_i,
  input  wire  [7:0] text_length_i,
  input  wire        first_of_text_i,
  input  wire        queue_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [7:0] text_pos_q, text_pos_d;
  logic [7:0] pos_now;
  logic       accept;
  logic       text_ok;
  logic       produces;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Position after an optional restart, and the length checks
  assign pos_now = first_of_text_i ? '0 : text_pos_q;
  assign text_ok = (text_length_i <= cfg_i.max_text_length) && (pos_now < text_length_i);

  // Classify the request into a queued job
  always_comb begin
    job_o.kind  = JOB_BYTE;
    job_o.rs    = 1'b0;
    job_o.value = value_i;
    produces    = 1'b1;
    unique case (req_type_e'(req_type_i))
      REQ_COMMAND: job_o.rs = 1'b0;
      REQ_DATA:    job_o.rs = 1'b1;
      REQ_POWERUP: job_o.kind = JOB_POWERUP;
      REQ_TEXT: begin
        job_o.rs   = 1'b1;
        job_o.kind = (pos_now == {3'b000, cfg_i.wrap_column}) ? JOB_WRAP_BYTE : JOB_BYTE;
        produces   = text_ok;
      end
      default: produces = 1'b0;
    endcase
  end

  assign push_o = accept && produces;

  // Text position: restart, then saturating advance on an emitted character
  always_comb begin
    text_pos_d = text_pos_q;
    if (accept && (req_type_e'(req_type_i) == REQ_TEXT)) begin
      if (text_ok && (pos_now != 8'hFF)) begin
        text_pos_d = pos_now + 1'b1;
      end else begin
        text_pos_d = pos_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_pos_q <= '0;
    end else begin
      text_pos_q <= text_pos_d;
    end
  end

  // Only text characters move the position
  a_pos_text_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i != REQ_TEXT)) |=> $stable(text_pos_q))
    else $error("text position moved on a non-text request");

endmodule

`default_nettype wire

### rtl/lcdnw_back.sv
// Back end: walks each queued job one nibble per cycle into the output register
// while that register is free. Depends on lcdnw_pkg; pops lcdnw_fifo.
`default_nettype none

module lcdnw_back import lcdnw_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cfg_t        cfg_i,
  input  wire         head_valid_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        reg_select_o,
  output logic [3:0]  data_nibble_o,
  output logic [15:0] wait_before_us_o,
  output logic [12:0] wait_after_us_o,
  output logic        last_of_run_o
);

  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             rs_q;
  logic [3:0]       nib_q;
  logic [15:0]      before_q;
  logic [12:0]      after_q;
  logic             last_q;

  logic             fire;
  logic             last_step;
  logic             nib_rs;
  logic [3:0]       nib;
  logic [15:0]      before_us;
  logic [12:0]      after;
  logic [7:0]       cur_byte;
  logic [1:0]       cmd_idx;
  logic [StepW-1:0] cmd_step;

  // Output register is free when empty or being taken
  assign fire  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = fire && last_step;

  assign cmd_step = step_q - FirstCmdStep;
  assign cmd_idx  = cmd_step[2:1];

  // Nibble, levels and hold times for the current step of the head job
  always_comb begin
    nib_rs    = head_i.rs;
    nib       = '0;
    before_us = '0;
    after     = '0;
    cur_byte  = head_i.value;
    last_step = 1'b0;
    unique case (head_i.kind)
      JOB_BYTE: begin
        last_step = (step_q == LastByteStep);
        nib       = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
        if (step_q[0]) begin
          after = head_i.rs ? 13'(cfg_i.data_wait_us) : 13'(cfg_i.command_wait_us);
        end
      end
      JOB_WRAP_BYTE: begin
        last_step = (step_q == LastWrapStep);
        if (!step_q[1]) begin
          cur_byte = LineTwoCmd;
          nib_rs   = 1'b0;
        end
        nib = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
        if (step_q[0]) begin
          after = step_q[1] ? 13'(cfg_i.data_wait_us) : 13'(cfg_i.command_wait_us);
        end
      end
      JOB_POWERUP: begin
        last_step = (step_q == LastPowerupStep);
        nib_rs    = 1'b0;
        if (step_q < FirstCmdStep) begin
          // raw function-set nibbles
          case (step_q[1:0])
            2'd0: begin
              nib       = PowerupNibA;
              before_us = PowerupWaitUs;
              after     = FirstHoldUs;
            end
            2'd3: begin
              nib   = PowerupNibB;
              after = NibbleWaitUs;
            end
            default: begin
              nib   = PowerupNibA;
              after = RepeatHoldUs;
            end
          endcase
        end else begin
          cur_byte = powerup_cmd(cmd_idx);
          nib      = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
          if (step_q[0]) begin
            after = 13'(cfg_i.command_wait_us)
                  + ((cmd_idx == ClearCmdIdx) ? ClearExtraUs : 13'd0);
          end
        end
      end
      default: last_step = 1'b1;
    endcase
  end

  // Step counter and output valid
  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      step_d      = last_step ? '0 : step_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rs_q     <= nib_rs;
      nib_q    <= nib;
      before_q <= before_us;
      after_q  <= after;
      last_q   <= last_step;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reg_select_o     = rs_q;
  assign data_nibble_o    = nib_q;
  assign wait_before_us_o = before_q;
  assign wait_after_us_o  = after_q;
  assign last_of_run_o    = last_q;

  // Step stays within the power-up run
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LastPowerupStep)
    else $error("step counter out of range");

  // A pop leaves the step counter at the start of the next job
  a_pop_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (step_q == '0))
    else $error("step counter not rewound after pop");

  // A fresh nibble loaded from a pop is marked as the last of its run
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && last_q))
    else $error("last nibble not flagged");

endmodule

`default_nettype wire

### rtl/lcd_nibble_write_sequencer_core.sv
// Top level of the LCD nibble write sequencer: APB registers, front, queue, back.
// Depends on lcdnw_pkg, lcdnw_front, lcdnw_fifo and lcdnw_back.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | req_type, value, text_length, first_of_text
//  out     | source    | out_valid_o/out_ready_i | reg_select, data_nibble, wait_before_us,
//          |           |                         | wait_after_us, last_of_run
//  apb     | slave     | psel, penable / pready  | paddr, pwdata, prdata (4 registers)
//
// The back end emits one nibble per cycle while the output is free: two nibbles for a
// command or data byte, four for a text character that wraps, twelve for the power-up
// run; that nibble loop sets the rate. The front takes one request per cycle while the
// job queue has room. A dropped text character is accepted at the front, emits nothing.
// An accepted job is queued, then its first nibble is loaded into the output register.
// Reset is asynchronous, active low, and restores register defaults and text position zero.
// A stalled output holds its register; the back end then stops and the queue fills.
`default_nettype none

module lcd_nibble_write_sequencer_core import lcdnw_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault  // at least 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // APB configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  req_type_i,
  input  wire  [7:0]  value_i,
  input  wire  [7:0]  text_length_i,
  input  wire         first_of_text_i,
  // nibble write channel
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        reg_select_o,
  output logic [3:0]  data_nibble_o,
  output logic [15:0] wait_before_us_o,
  output logic [12:0] wait_after_us_o,
  output logic        last_of_run_o
);

  cfg_t       cfg_q;
  logic       cfg_wr;
  cfg_index_e cfg_idx;

  logic       push;
  job_t       push_job;
  logic       queue_full;
  logic       queue_empty;
  logic       pop;
  job_t       head_job;

  // Register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_index_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.command_wait_us <= CommandWaitReset;
      cfg_q.data_wait_us    <= DataWaitReset;
      cfg_q.wrap_column     <= WrapColumnReset;
      cfg_q.max_text_length <= MaxTextLenReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_COMMAND_WAIT: cfg_q.command_wait_us <= pwdata[7:0];
        CFG_DATA_WAIT:    cfg_q.data_wait_us    <= pwdata[7:0];
        CFG_WRAP_COLUMN:  cfg_q.wrap_column     <= pwdata[4:0];
        CFG_MAX_TEXT_LEN: cfg_q.max_text_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      CFG_COMMAND_WAIT: prdata = {24'd0, cfg_q.command_wait_us};
      CFG_DATA_WAIT:    prdata = {24'd0, cfg_q.data_wait_us};
      CFG_WRAP_COLUMN:  prdata = {27'd0, cfg_q.wrap_column};
      CFG_MAX_TEXT_LEN: prdata = {24'd0, cfg_q.max_text_length};
      default:          prdata = '0;
    endcase
  end

  lcdnw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .text_length_i   (text_length_i),
    .first_of_text_i (first_of_text_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  lcdnw_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (queue_empty)
  );

  lcdnw_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_valid_i     (!queue_empty),
    .head_i           (head_job),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .reg_select_o     (reg_select_o),
    .data_nibble_o    (data_nibble_o),
    .wait_before_us_o (wait_before_us_o),
    .wait_after_us_o  (wait_after_us_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

`default_nettype wire
